[rtl/occluded_column_span_clipper_unit_assert.svh]
// Assertion macros used by the checker file ocsc_checker.sv.
`ifndef OCCLUDED_COLUMN_SPAN_CLIPPER_UNIT_ASSERT_SVH
`define OCCLUDED_COLUMN_SPAN_CLIPPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OCSC_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("ocsc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OCSC_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("ocsc assertion failed");

`endif

[rtl/ocsc_pkg.sv]
package ocsc_pkg;

   localparam int MAX_SPANS = 32;
   localparam int ADDR_W    = $clog2(MAX_SPANS);
   localparam int COUNT_W   = $clog2(MAX_SPANS + 2);
   localparam int RES_CAP   = MAX_SPANS + 1;

   localparam logic [1:0] MODE_STORE  = 2'd1;
   localparam logic [1:0] MODE_INSERT = 2'd2;

   typedef struct packed {
      logic signed [15:0] right;
      logic signed [15:0] left;
   } span_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_W_CHECK,
      ST_W_EVAL,
      ST_P_START,
      ST_P_R0,
      ST_P_STEP,
      ST_P_RN,
      ST_P_FOUND,
      ST_P_SHIFT,
      ST_P_SHWR,
      ST_P_DONE,
      ST_EMIT,
      ST_FINAL,
      ST_INS_OUT
   } state_type;

endpackage

[rtl/ocsc_span_ram.sv]
module ocsc_span_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ocsc_pkg::ADDR_W-1:0]     wr_addr,
   input  ocsc_pkg::span_type              wr_data,
   input  logic                            rd_en,
   input  logic [ocsc_pkg::ADDR_W-1:0]     rd_addr,
   output ocsc_pkg::span_type              rd_data
);

   ocsc_pkg::span_type mem [ocsc_pkg::MAX_SPANS];
   ocsc_pkg::span_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/occluded_column_span_clipper_unit.sv]
// Occluded column span clipper.
// The req channel takes one command item: tuser carries the mode (probe, clip
// and store, insert), tdata the inclusive span. The rsp channel returns the
// result items of that command in order, the final one marked by tlast.
// A probe or a clip walks the stored span table entry by entry, one memory
// read and one evaluation per entry, and hands over each emitted piece in
// turn. Storing a piece or inserting a span scans the table for its slot,
// one entry read at a time, and then, if a slot fits and the table has
// room, shifts the entries above it up by one. The longest command is a
// clip and store that fills the table; the single read port and single
// write port of the span memory set the pace of every command.
// One command is worked on at a time; req_tready is high only when idle.
// A finished result waits in the output register, and the next command is
// accepted while it waits. When the receiver stalls, the walk holds before
// the next result it would hand over. Reset empties the table (the count
// goes to zero) and drops any result not yet taken.
module occluded_column_span_clipper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // seg_left [15:0], seg_right [31:16]
   input  logic [1:0]  req_tuser,   // mode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // piece_left [15:0], piece_right [31:16]
   output logic [2:0]  rsp_tuser,   // piece_valid, insert_ok, store_dropped
   output logic        rsp_tlast
);

   localparam int AW = ocsc_pkg::ADDR_W;
   localparam int CW = ocsc_pkg::COUNT_W;

   ocsc_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] s_ff, s_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic signed [16:0] xl_ff, xl_in;
   logic signed [15:0] xr_ff, xr_in;
   logic signed [15:0] rj_ff, rj_in;
   logic signed [15:0] pc_lo_ff, pc_lo_in;
   logic signed [15:0] pc_hi_ff, pc_hi_in;
   logic pc_ok_ff, pc_ok_in;
   logic pc_drop_ff, pc_drop_in;
   logic tail_ff, tail_in;
   logic store_ff, store_in;
   logic ins_ff, ins_in;
   logic pend_valid_ff, pend_valid_in;
   logic signed [15:0] pend_lo_ff, pend_lo_in;
   logic signed [15:0] pend_hi_ff, pend_hi_in;
   logic pend_drop_ff, pend_drop_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [2:0] rsp_user_ff, rsp_user_in;
   logic rsp_last_ff, rsp_last_in;

   logic mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   ocsc_pkg::span_type mem_wr_data, mem_rd_data;

   logic signed [16:0] lo_x, hi_p1, xr_x;
   logic walk_go, tail_go, c_before, c_gap, c_cover;
   logic p_front, p_last, p_fit_last, p_fit, full, shift_more;
   logic out_free, emit_block;

   ocsc_span_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign lo_x  = 17'(mem_rd_data.left);
   assign hi_p1 = 17'(mem_rd_data.right) + 17'sd1;
   assign xr_x  = 17'(xr_ff);

   assign walk_go    = (i_ff < count_ff) && (xl_ff <= xr_x)
                       && (k_ff < CW'(ocsc_pkg::RES_CAP));
   assign tail_go    = (xl_ff <= xr_x) && (k_ff < CW'(ocsc_pkg::RES_CAP));
   assign c_before   = xr_x < lo_x;
   assign c_gap      = xl_ff < lo_x;
   assign c_cover    = hi_p1 > xl_ff;
   assign p_front    = pc_hi_ff <= mem_rd_data.left;
   assign p_last     = (j_ff + CW'(1)) >= count_ff;
   assign p_fit_last = rj_ff <= pc_lo_ff;
   assign p_fit      = (rj_ff <= pc_lo_ff) && (pc_hi_ff <= mem_rd_data.left);
   assign full       = count_ff >= CW'(ocsc_pkg::MAX_SPANS);
   assign shift_more = s_ff > pos_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_block = pend_valid_ff && !out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ocsc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == ocsc_pkg::MODE_INSERT) ?
                          ocsc_pkg::ST_P_START : ocsc_pkg::ST_W_CHECK;
            end
         end
         ocsc_pkg::ST_W_CHECK: begin
            if (walk_go) begin
               state_in = ocsc_pkg::ST_W_EVAL;
            end else if (tail_go) begin
               state_in = store_ff ? ocsc_pkg::ST_P_START : ocsc_pkg::ST_EMIT;
            end else begin
               state_in = ocsc_pkg::ST_FINAL;
            end
         end
         ocsc_pkg::ST_W_EVAL: begin
            if (c_before || c_gap) begin
               state_in = store_ff ? ocsc_pkg::ST_P_START : ocsc_pkg::ST_EMIT;
            end else begin
               state_in = ocsc_pkg::ST_W_CHECK;
            end
         end
         ocsc_pkg::ST_P_START: begin
            state_in = (count_ff == '0) ? ocsc_pkg::ST_P_FOUND : ocsc_pkg::ST_P_R0;
         end
         ocsc_pkg::ST_P_R0: begin
            state_in = p_front ? ocsc_pkg::ST_P_FOUND : ocsc_pkg::ST_P_STEP;
         end
         ocsc_pkg::ST_P_STEP: begin
            if (p_last) begin
               state_in = p_fit_last ? ocsc_pkg::ST_P_FOUND : ocsc_pkg::ST_P_DONE;
            end else begin
               state_in = ocsc_pkg::ST_P_RN;
            end
         end
         ocsc_pkg::ST_P_RN: begin
            state_in = p_fit ? ocsc_pkg::ST_P_FOUND : ocsc_pkg::ST_P_STEP;
         end
         ocsc_pkg::ST_P_FOUND: begin
            state_in = full ? ocsc_pkg::ST_P_DONE : ocsc_pkg::ST_P_SHIFT;
         end
         ocsc_pkg::ST_P_SHIFT: begin
            state_in = shift_more ? ocsc_pkg::ST_P_SHWR : ocsc_pkg::ST_P_DONE;
         end
         ocsc_pkg::ST_P_SHWR: begin
            state_in = ocsc_pkg::ST_P_SHIFT;
         end
         ocsc_pkg::ST_P_DONE: begin
            state_in = ins_ff ? ocsc_pkg::ST_INS_OUT : ocsc_pkg::ST_EMIT;
         end
         ocsc_pkg::ST_EMIT: begin
            if (!emit_block) begin
               state_in = tail_ff ? ocsc_pkg::ST_FINAL : ocsc_pkg::ST_W_CHECK;
            end
         end
         ocsc_pkg::ST_FINAL, ocsc_pkg::ST_INS_OUT: begin
            if (out_free) begin
               state_in = ocsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ocsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      s_in          = s_ff;
      pos_in        = pos_ff;
      xl_in         = xl_ff;
      xr_in         = xr_ff;
      rj_in         = rj_ff;
      pc_lo_in      = pc_lo_ff;
      pc_hi_in      = pc_hi_ff;
      pc_ok_in      = pc_ok_ff;
      pc_drop_in    = pc_drop_ff;
      tail_in       = tail_ff;
      store_in      = store_ff;
      ins_in        = ins_ff;
      pend_valid_in = pend_valid_ff;
      pend_lo_in    = pend_lo_ff;
      pend_hi_in    = pend_hi_ff;
      pend_drop_in  = pend_drop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pos_ff[AW-1:0];
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = i_ff[AW-1:0];
      unique case (state_ff)
         ocsc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               xl_in         = 17'($signed(req_tdata[15:0]));
               xr_in         = req_tdata[31:16];
               pc_lo_in      = req_tdata[15:0];
               pc_hi_in      = req_tdata[31:16];
               pc_ok_in      = 1'b0;
               pc_drop_in    = 1'b0;
               i_in          = '0;
               k_in          = '0;
               pend_valid_in = 1'b0;
               store_in      = req_tuser == ocsc_pkg::MODE_STORE;
               ins_in        = req_tuser == ocsc_pkg::MODE_INSERT;
            end
         end
         ocsc_pkg::ST_W_CHECK: begin
            if (walk_go) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = i_ff[AW-1:0];
            end else if (tail_go) begin
               pc_lo_in   = xl_ff[15:0];
               pc_hi_in   = xr_ff;
               pc_ok_in   = 1'b0;
               pc_drop_in = 1'b0;
               tail_in    = 1'b1;
            end
         end
         ocsc_pkg::ST_W_EVAL: begin
            pc_ok_in   = 1'b0;
            pc_drop_in = 1'b0;
            tail_in    = 1'b0;
            if (c_before) begin
               pc_lo_in = xl_ff[15:0];
               pc_hi_in = xr_ff;
               xl_in    = xr_x + 17'sd1;
            end else if (c_gap) begin
               pc_lo_in = xl_ff[15:0];
               pc_hi_in = 16'(lo_x - 17'sd1);
               xl_in    = hi_p1;
            end else begin
               if (c_cover) begin
                  xl_in = hi_p1;
               end
               i_in = i_ff + CW'(1);
            end
         end
         ocsc_pkg::ST_P_START: begin
            pos_in      = '0;
            mem_rd_en   = count_ff != '0;
            mem_rd_addr = '0;
         end
         ocsc_pkg::ST_P_R0: begin
            pos_in = '0;
            rj_in  = mem_rd_data.right;
            j_in   = '0;
         end
         ocsc_pkg::ST_P_STEP: begin
            pos_in = j_ff + CW'(1);
            if (!p_last) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(j_ff + CW'(1));
            end
         end
         ocsc_pkg::ST_P_RN: begin
            pos_in = j_ff + CW'(1);
            rj_in  = mem_rd_data.right;
            j_in   = j_ff + CW'(1);
         end
         ocsc_pkg::ST_P_FOUND: begin
            pc_drop_in = full;
            s_in       = count_ff;
         end
         ocsc_pkg::ST_P_SHIFT: begin
            if (shift_more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(s_ff - CW'(1));
            end else begin
               mem_wr_en         = 1'b1;
               mem_wr_addr       = pos_ff[AW-1:0];
               mem_wr_data.left  = pc_lo_ff;
               mem_wr_data.right = pc_hi_ff;
               count_in          = count_ff + CW'(1);
               pc_ok_in          = 1'b1;
            end
         end
         ocsc_pkg::ST_P_SHWR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = s_ff[AW-1:0];
            mem_wr_data = mem_rd_data;
            s_in        = s_ff - CW'(1);
         end
         ocsc_pkg::ST_P_DONE: begin
         end
         ocsc_pkg::ST_EMIT: begin
            if (!emit_block) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {pend_hi_ff, pend_lo_ff};
                  rsp_user_in  = {pend_drop_ff, 1'b0, 1'b1};
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_lo_in    = pc_lo_ff;
               pend_hi_in    = pc_hi_ff;
               pend_drop_in  = pc_drop_ff;
               k_in          = k_ff + CW'(1);
               i_in          = i_ff + CW'(1)
                               + CW'(pc_ok_ff && (pos_ff <= i_ff));
            end
         end
         ocsc_pkg::ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in = {pend_hi_ff, pend_lo_ff};
                  rsp_user_in = {pend_drop_ff, 1'b0, 1'b1};
               end else begin
                  rsp_data_in = '0;
                  rsp_user_in = '0;
               end
            end
         end
         ocsc_pkg::ST_INS_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {pc_hi_ff, pc_lo_ff};
               rsp_user_in  = {pc_drop_ff, pc_ok_ff, 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ocsc_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      s_ff         <= s_in;
      pos_ff       <= pos_in;
      xl_ff        <= xl_in;
      xr_ff        <= xr_in;
      rj_ff        <= rj_in;
      pc_lo_ff     <= pc_lo_in;
      pc_hi_ff     <= pc_hi_in;
      pc_ok_ff     <= pc_ok_in;
      pc_drop_ff   <= pc_drop_in;
      tail_ff      <= tail_in;
      store_ff     <= store_in;
      ins_ff       <= ins_in;
      pend_lo_ff   <= pend_lo_in;
      pend_hi_ff   <= pend_hi_in;
      pend_drop_ff <= pend_drop_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = state_ff == ocsc_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/ocsc_checker.sv]
`include "occluded_column_span_clipper_unit_assert.svh"

module ocsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `OCSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `OCSC_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast)
   `OCSC_ASSERT_IMP(a_insert_ok_form, clock, reset, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0] && !rsp_tuser[2])
   `OCSC_ASSERT_IMP(a_piece_ordered, clock, reset, rsp_tvalid && rsp_tuser[0], $signed(rsp_tdata[15:0]) <= $signed(rsp_tdata[31:16]))

endmodule

bind occluded_column_span_clipper_unit ocsc_checker u_ocsc_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] MODE_PROBE = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      bit                 valid;
      logic signed [15:0] left;
      logic signed [15:0] right;
      bit                 last;
      bit                 ok;
      bit                 dropped;
   } piece_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   piece_type pending_pieces[$];
   int        cover_left[ocsc_pkg::MAX_SPANS];
   int        cover_right[ocsc_pkg::MAX_SPANS];
   int        cover_count;
   int        error_count = 0;
   bit        quiet;
   int        stall_left = 0;

   occluded_column_span_clipper_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Returns the slot used, -1 when no slot fits, -2 when a slot fits but the table is full.
   function automatic int place_cover(int lo, int hi);
      int pos;
      bit found;
      found = 0;
      pos = 0;
      if (cover_count == 0 || hi <= cover_left[0]) begin
         found = 1;
      end else begin
         for (int i = 0; i < cover_count; i++) begin
            if (cover_right[i] <= lo &&
                (i + 1 >= cover_count || hi <= cover_left[i + 1])) begin
               found = 1;
               pos = i + 1;
               break;
            end
         end
      end
      if (!found) return -1;
      if (cover_count >= ocsc_pkg::MAX_SPANS) return -2;
      for (int i = cover_count; i > pos; i--) begin
         cover_left[i] = cover_left[i - 1];
         cover_right[i] = cover_right[i - 1];
      end
      cover_left[pos] = lo;
      cover_right[pos] = hi;
      cover_count++;
      return pos;
   endfunction

   function automatic void add_piece(bit store, int lo, int hi, ref int walk);
      piece_type p;
      int slot;
      p.dropped = 0;
      if (store) begin
         slot = place_cover(lo, hi);
         if (slot == -2) p.dropped = 1;
         else if (slot >= 0 && slot <= walk) walk++;
      end
      p.valid = 1;
      p.left = lo[15:0];
      p.right = hi[15:0];
      p.last = 0;
      p.ok = 0;
      pending_pieces.push_back(p);
   endfunction

   function automatic void predict_pieces(logic [1:0] mode, logic signed [15:0] l,
                                          logic signed [15:0] r);
      int xl;
      int xr;
      int walk;
      int n;
      int lo;
      int hi;
      bit store;
      piece_type p;
      xl = l;
      xr = r;
      walk = 0;
      store = (mode == ocsc_pkg::MODE_STORE);
      n = pending_pieces.size();
      if (mode == ocsc_pkg::MODE_INSERT) begin
         lo = place_cover(xl, xr);
         p.valid = 0;
         p.left = l;
         p.right = r;
         p.last = 1;
         p.ok = (lo >= 0);
         p.dropped = (lo == -2);
         pending_pieces.push_back(p);
         return;
      end
      while (walk < cover_count && xl <= xr &&
             pending_pieces.size() - n < ocsc_pkg::RES_CAP) begin
         lo = cover_left[walk];
         hi = cover_right[walk];
         if (xr < lo) begin
            add_piece(store, xl, xr, walk);
            xl = xr + 1;
         end else if (xl < lo) begin
            add_piece(store, xl, lo - 1, walk);
            xl = hi + 1;
         end else if (hi + 1 > xl) begin
            xl = hi + 1;
         end
         walk++;
      end
      if (xl <= xr && pending_pieces.size() - n < ocsc_pkg::RES_CAP)
         add_piece(store, xl, xr, walk);
      if (pending_pieces.size() == n) begin
         p.valid = 0;
         p.left = 0;
         p.right = 0;
         p.last = 0;
         p.ok = 0;
         p.dropped = 0;
         pending_pieces.push_back(p);
      end
      pending_pieces[pending_pieces.size() - 1].last = 1;
   endfunction

   task automatic send_command(logic [1:0] mode, logic signed [15:0] l,
                               logic signed [15:0] r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {r, l};
      do @(posedge clock); while (!req_tready);
      predict_pieces(mode, l, r);
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      piece_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pieces.size() == 0) begin
            report_mismatch("result item with nothing expected");
         end else begin
            e = pending_pieces.pop_front();
            if (rsp_tuser[0] !== e.valid || rsp_tdata[15:0] !== e.left ||
                rsp_tdata[31:16] !== e.right || rsp_tlast !== e.last ||
                rsp_tuser[1] !== e.ok || rsp_tuser[2] !== e.dropped)
               report_mismatch($sformatf(
                  "got v%0b [%0d,%0d] l%0b ok%0b dr%0b, want v%0b [%0d,%0d] l%0b ok%0b dr%0b",
                  rsp_tuser[0], $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]),
                  rsp_tlast, rsp_tuser[1], rsp_tuser[2], e.valid, e.left, e.right,
                  e.last, e.ok, e.dropped));
         end
      end
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_directed_inserts();
      send_command(MODE_PROBE, -16'sd32768, 16'sd32767);
      send_command(ocsc_pkg::MODE_INSERT, 16'sd0, 16'sd10);
      send_command(ocsc_pkg::MODE_INSERT, 16'sd10, 16'sd20);
      send_command(ocsc_pkg::MODE_INSERT, 16'sd5, 16'sd15);
      send_command(ocsc_pkg::MODE_INSERT, -16'sd100, -16'sd50);
      send_command(ocsc_pkg::MODE_INSERT, 16'sd32000, 16'sd32767);
      send_command(ocsc_pkg::MODE_INSERT, -16'sd32768, -16'sd32760);
   endtask

   task automatic test_directed_clips();
      send_command(MODE_PROBE, -16'sd200, 16'sd100);
      send_command(MODE_PROBE, 16'sd2, 16'sd8);
      send_command(MODE_PROBE, 16'sd50, 16'sd40);
      send_command(MODE_SPARE, -16'sd60, 16'sd30);
      send_command(MODE_PROBE, 16'sd31990, 16'sd32767);
      send_command(MODE_PROBE, -16'sd32768, -16'sd32700);
      send_command(ocsc_pkg::MODE_STORE, -16'sd40, 16'sd40);
      send_command(ocsc_pkg::MODE_STORE, 16'sd30, 16'sd20);
      send_command(ocsc_pkg::MODE_STORE, 16'sd31990, 16'sd32767);
      send_command(MODE_PROBE, -16'sd32768, 16'sd32767);
      send_command(ocsc_pkg::MODE_INSERT, 16'sd100, 16'sd90);
      send_command(ocsc_pkg::MODE_STORE, -16'sd32768, 16'sd32767);
      send_command(ocsc_pkg::MODE_INSERT, 16'sd500, 16'sd600);
      send_command(MODE_PROBE, -16'sd32768, 16'sd32767);
   endtask

   task automatic test_random_traffic(int count);
      logic [1:0]         mode;
      logic signed [15:0] l;
      logic signed [15:0] r;
      int                 pick;
      for (int n = 0; n < count; n++) begin
         if (n >= count - 40) quiet = 1;
         pick = $urandom_range(0, 9);
         mode = pick < 3 ? MODE_PROBE : pick < 6 ? ocsc_pkg::MODE_STORE :
                pick < 9 ? ocsc_pkg::MODE_INSERT : MODE_SPARE;
         if ($urandom_range(0, 6) != 0) begin
            l = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
            r = l + $signed(16'($urandom_range(0, 60))) - 16'sd2;
         end else begin
            l = 16'($urandom);
            r = 16'($urandom);
         end
         send_command(mode, l, r);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_PROBE;
      quiet = 0;
      cover_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_inserts();
      test_directed_clips();
      test_random_traffic(200);
      req_tvalid <= 1'b0;
      while (pending_pieces.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0 && pending_pieces.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/ocsc_pkg.sv
rtl/ocsc_span_ram.sv
rtl/occluded_column_span_clipper_unit.sv
rtl/ocsc_checker.sv
dv/testbench.sv
